### sv/pecpd_pkg.sv
package pecpd_pkg;

    // Default ring depth for the edge history.
    localparam int RING_DEPTH = 4;

    // Field widths fixed by the interface.
    localparam int FUNC_W  = 2;
    localparam int TIME_W  = 32;
    localparam int GAP_W   = 16;
    localparam int CHAN_W  = 8;
    localparam int COUNT_W = 32;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Highest channel index; the index saturates here.
    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    // Request function codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_RISE  = 2'd0,
        FUNC_FALL  = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_CHAN_COUNT  = 3'd1,
        CFG_SYNC_THRESH = 3'd2,
        CFG_RANGE_CHECK = 3'd3,
        CFG_POS_MIN     = 3'd4,
        CFG_POS_MAX     = 3'd5
    } t_cfg_idx;

    // Mode bit positions.
    localparam int MODE_COUNT_FALL = 0;
    localparam int MODE_POS_RISE   = 1;
    localparam int MODE_POS_FALL   = 2;

    // Position decode settings handed to the gap decoder.
    typedef struct packed {
        logic [CHAN_W-1:0] channel_count;
        logic [GAP_W-1:0]  sync_threshold;
        logic              range_check;
        logic [GAP_W-1:0]  pos_min;
        logic [GAP_W-1:0]  pos_max;
    } t_pos_cfg;

    // Outcome of decoding one gap.
    typedef struct packed {
        logic              write;
        logic              sync;
        logic [CHAN_W-1:0] channel;
        logic [GAP_W-1:0]  value;
        logic [CHAN_W-1:0] next_chan;
    } t_gap_result;

endpackage

### sv/pecpd_gap_decode.sv
module pecpd_gap_decode (
    input  logic [pecpd_pkg::GAP_W-1:0]  i_gap,
    input  logic [pecpd_pkg::CHAN_W-1:0] i_chan,
    input  pecpd_pkg::t_pos_cfg          i_cfg,
    output pecpd_pkg::t_gap_result       o_result
);

    logic in_range;
    logic below_sync;

    // A gap below the threshold is a channel pulse; otherwise it is frame sync.
    assign below_sync = i_gap < i_cfg.sync_threshold;
    assign in_range   = !i_cfg.range_check ||
                        ((i_gap >= i_cfg.pos_min) && (i_gap <= i_cfg.pos_max));

    always_comb begin
        o_result = '0;
        if (below_sync) begin
            if ((i_chan < i_cfg.channel_count) && in_range) begin
                o_result.write   = 1'b1;
                o_result.channel = i_chan;
                o_result.value   = i_gap;
            end
            // The channel index advances even when nothing is written.
            if (i_chan != pecpd_pkg::CHAN_MAX) begin
                o_result.next_chan = i_chan + 1'b1;
            end else begin
                o_result.next_chan = i_chan;
            end
        end else begin
            o_result.sync      = 1'b1;
            o_result.next_chan = '0;
        end
    end

endmodule

### sv/pulse_edge_capture_ppm_decoder.sv
// Pulse edge capture with PPM position decode.
//
// Input channel: each request carries a function (rising edge, falling edge or
// clear) and a 32-bit microsecond timestamp. Output channel: one result per
// request with period, low width, high width, the falling-edge total and an
// optional position write or frame sync indication. Configuration is written
// through a plain write port while the block is idle; only the user ensures this.
//
// o_out_valid rises in the cycle after acceptance. Throughput is one request
// per cycle while the receiver does not stall: the edge history and counters
// update in the same cycle a request is accepted, and the result lands in a
// single output register. When the receiver stalls, the held result stays
// stable and o_in_stall is raised only while that output register is occupied.
//
// Reset (synchronous, active low) clears the edge history, the counters, the
// channel index, all configuration registers and the output valid.
module pulse_edge_capture_ppm_decoder #(
    parameter int RING_DEPTH = pecpd_pkg::RING_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pecpd_pkg::FUNC_W-1:0]        i_in_func,
    input  logic [pecpd_pkg::TIME_W-1:0]        i_in_time_us,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pecpd_pkg::GAP_W-1:0]         o_out_period_us,
    output logic [pecpd_pkg::GAP_W-1:0]         o_out_low_width_us,
    output logic [pecpd_pkg::GAP_W-1:0]         o_out_high_width_us,
    output logic [pecpd_pkg::COUNT_W-1:0]       o_out_falling_total,
    output logic                                o_out_pos_write,
    output logic [pecpd_pkg::CHAN_W-1:0]        o_out_pos_channel,
    output logic [pecpd_pkg::GAP_W-1:0]         o_out_pos_value,
    output logic                                o_out_frame_sync,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [pecpd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pecpd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);

    localparam int GW = pecpd_pkg::GAP_W;

    // Configuration registers
    logic [pecpd_pkg::MODE_W-1:0] r_mode;
    pecpd_pkg::t_pos_cfg          r_pos_cfg;

    // Edge history. Only the low 16 bits of a time ever reach a result.
    logic [GW-1:0]     r_rise [RING_DEPTH];
    logic [GW-1:0]     n_rise [RING_DEPTH];
    logic [SLOT_W-1:0] r_ws, n_ws;
    logic              r_primed, n_primed;     // a falling edge closed a slot
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [GW-1:0]     r_last_rise, n_last_rise; // rising time of the last slot
    logic [GW-1:0]     r_last_fall, n_last_fall; // falling time of the last slot
    logic [GW-1:0]     r_prev_fall, n_prev_fall; // falling time of the slot before
    logic [pecpd_pkg::COUNT_W-1:0] r_fall_cnt, n_fall_cnt;
    logic [pecpd_pkg::CHAN_W-1:0]  r_chan, n_chan;

    // Output register
    logic                          r_out_valid;
    logic [GW-1:0]                 r_period, r_low, r_high, r_pos_value;
    logic [GW-1:0]                 n_period, n_low, n_high, n_pos_value;
    logic [pecpd_pkg::COUNT_W-1:0] r_total;
    logic                          r_pos_write, n_pos_write;
    logic [pecpd_pkg::CHAN_W-1:0]  r_pos_channel, n_pos_channel;
    logic                          r_sync, n_sync;

    logic                   accept;
    logic                   dec_en;
    logic [GW-1:0]          gap;
    logic [GW-1:0]          t16;
    pecpd_pkg::t_gap_result dec;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign t16        = i_in_time_us[GW-1:0];

    // Pick the gap to decode: against the last closed slot of the same edge kind.
    // Before any slot is closed, the gap is zero.
    always_comb begin
        dec_en = 1'b0;
        gap    = '0;
        case (pecpd_pkg::t_func'(i_in_func))
            pecpd_pkg::FUNC_RISE: begin
                dec_en = r_mode[pecpd_pkg::MODE_POS_RISE];
                gap    = r_primed ? (t16 - r_last_rise) : '0;
            end
            pecpd_pkg::FUNC_FALL: begin
                dec_en = r_mode[pecpd_pkg::MODE_POS_FALL];
                gap    = r_primed ? (t16 - r_last_fall) : '0;
            end
            default: begin
                dec_en = 1'b0;
                gap    = '0;
            end
        endcase
    end

    pecpd_gap_decode u_gap_decode (
        .i_gap    (gap),
        .i_chan   (r_chan),
        .i_cfg    (r_pos_cfg),
        .o_result (dec)
    );

    // Next state of the edge history and counters for one request.
    always_comb begin
        n_rise      = r_rise;
        n_ws        = r_ws;
        n_primed    = r_primed;
        n_fill      = r_fill;
        n_last_rise = r_last_rise;
        n_last_fall = r_last_fall;
        n_prev_fall = r_prev_fall;
        n_fall_cnt  = r_fall_cnt;
        n_chan      = dec_en ? dec.next_chan : r_chan;
        case (pecpd_pkg::t_func'(i_in_func))
            pecpd_pkg::FUNC_RISE: begin
                n_rise[r_ws] = t16;
                if (!r_primed) begin
                    n_last_rise = t16;
                end
                if (r_fill != FILL_FULL) begin
                    n_fill = r_fill + 1'b1;
                end
            end
            pecpd_pkg::FUNC_FALL: begin
                // Close the current slot and move on to the next one.
                n_last_rise = r_rise[r_ws];
                n_last_fall = t16;
                n_prev_fall = r_last_fall;
                n_primed    = 1'b1;
                n_ws        = (r_ws == LAST_SLOT) ? '0 : r_ws + 1'b1;
                if (r_mode[pecpd_pkg::MODE_COUNT_FALL]) begin
                    n_fall_cnt = r_fall_cnt + 1'b1;
                end
                if (r_fill != FILL_FULL) begin
                    n_fill = r_fill + 1'b1;
                end
            end
            pecpd_pkg::FUNC_CLEAR: begin
                for (int i = 0; i < RING_DEPTH; i++) begin
                    n_rise[i] = '0;
                end
                n_ws        = '0;
                n_primed    = 1'b0;
                n_fill      = '0;
                n_last_rise = '0;
                n_last_fall = '0;
                n_prev_fall = '0;
                n_fall_cnt  = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    // Result fields, taken from the state after this request.
    always_comb begin
        if (n_fill == FILL_FULL) begin
            n_period = n_last_fall - n_prev_fall;
            n_low    = n_last_rise - n_prev_fall;
            n_high   = n_last_fall - n_last_rise;
        end else begin
            n_period = '0;
            n_low    = '0;
            n_high   = '0;
        end
        n_pos_write   = dec_en && dec.write;
        n_pos_channel = dec_en ? dec.channel : '0;
        n_pos_value   = dec_en ? dec.value : '0;
        n_sync        = dec_en && dec.sync;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= '0;
            r_pos_cfg <= '0;
        end else if (i_cfg_we) begin
            case (pecpd_pkg::t_cfg_idx'(i_cfg_idx))
                pecpd_pkg::CFG_MODE:        r_mode <= i_cfg_data[pecpd_pkg::MODE_W-1:0];
                pecpd_pkg::CFG_CHAN_COUNT:  begin
                    r_pos_cfg.channel_count <= i_cfg_data[pecpd_pkg::CHAN_W-1:0];
                end
                pecpd_pkg::CFG_SYNC_THRESH: r_pos_cfg.sync_threshold <= i_cfg_data[GW-1:0];
                pecpd_pkg::CFG_RANGE_CHECK: r_pos_cfg.range_check <= i_cfg_data[0];
                pecpd_pkg::CFG_POS_MIN:     r_pos_cfg.pos_min <= i_cfg_data[GW-1:0];
                pecpd_pkg::CFG_POS_MAX:     r_pos_cfg.pos_max <= i_cfg_data[GW-1:0];
                default:                    r_mode <= r_mode;
            endcase
        end
    end

    // Edge history and counters update on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_rise[i] <= '0;
            end
            r_ws        <= '0;
            r_primed    <= 1'b0;
            r_fill      <= '0;
            r_last_rise <= '0;
            r_last_fall <= '0;
            r_prev_fall <= '0;
            r_fall_cnt  <= '0;
            r_chan      <= '0;
        end else if (accept) begin
            r_rise      <= n_rise;
            r_ws        <= n_ws;
            r_primed    <= n_primed;
            r_fill      <= n_fill;
            r_last_rise <= n_last_rise;
            r_last_fall <= n_last_fall;
            r_prev_fall <= n_prev_fall;
            r_fall_cnt  <= n_fall_cnt;
            r_chan      <= n_chan;
        end
    end

    // Output valid: filled on acceptance, emptied when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= i_in_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_period      <= n_period;
            r_low         <= n_low;
            r_high        <= n_high;
            r_total       <= n_fall_cnt;
            r_pos_write   <= n_pos_write;
            r_pos_channel <= n_pos_channel;
            r_pos_value   <= n_pos_value;
            r_sync        <= n_sync;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_period_us     = r_period;
    assign o_out_low_width_us  = r_low;
    assign o_out_high_width_us = r_high;
    assign o_out_falling_total = r_total;
    assign o_out_pos_write     = r_pos_write;
    assign o_out_pos_channel   = r_pos_channel;
    assign o_out_pos_value     = r_pos_value;
    assign o_out_frame_sync    = r_sync;

endmodule
